// ===== hdl/i2cm_pkg.sv =====
// Shared types and codes for the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned DelayW = 16;

  // Operation codes on the input stream
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  typedef enum logic [2:0] {
    KIND_NOP   = 3'd0,
    KIND_TICK  = 3'd1,
    KIND_START = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4,
    KIND_STOP  = 3'd5
  } kind_e;

  // One classified item waiting for the back end
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic       rejected;
    logic       busy_res;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       sda_low;
    logic       scl_low;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/i2cm_front.sv =====
// Front end: accepts input transfers, decodes the operation and queues them.
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        send_ack_i,
  input  wire logic        scl_in_i,
  input  wire logic        sda_in_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_pop_i,
  output cmd_t             cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  kind_e      kind;
  cmd_t       cmd_in;

  always_comb begin
    case (op_i)
      OP_TICK:  kind = KIND_TICK;
      OP_START: kind = KIND_START;
      OP_WRITE: kind = KIND_WRITE;
      OP_READ:  kind = KIND_READ;
      OP_STOP:  kind = KIND_STOP;
      default:  kind = KIND_NOP;
    endcase
  end

  always_comb begin
    cmd_in.kind      = kind;
    cmd_in.data_byte = data_byte_i;
    cmd_in.send_ack  = send_ack_i;
    cmd_in.scl_in    = scl_in_i;
    cmd_in.sda_in    = sda_in_i;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2cm_back.sv =====
// Back end: bus sequencer stepped by queued items, with the result register.
`default_nettype none

module i2cm_back
  import i2cm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DelayW-1:0] cfg_wdata_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  input  wire cmd_t              cmd_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_ST_WAIT   = 5'd1;
  localparam logic [4:0] PH_ST_D1     = 5'd2;
  localparam logic [4:0] PH_ST_D2     = 5'd3;
  localparam logic [4:0] PH_WR_SETUP  = 5'd4;
  localparam logic [4:0] PH_WR_HIGH   = 5'd5;
  localparam logic [4:0] PH_WR_ASETUP = 5'd6;
  localparam logic [4:0] PH_WR_AHIGH  = 5'd7;
  localparam logic [4:0] PH_WR_AWAIT  = 5'd8;
  localparam logic [4:0] PH_WR_AEND   = 5'd9;
  localparam logic [4:0] PH_RD_HIGH   = 5'd10;
  localparam logic [4:0] PH_RD_LOW    = 5'd11;
  localparam logic [4:0] PH_RD_ASETUP = 5'd12;
  localparam logic [4:0] PH_RD_AHIGH  = 5'd13;
  localparam logic [4:0] PH_RD_AEND   = 5'd14;
  localparam logic [4:0] PH_SP_LOW    = 5'd15;
  localparam logic [4:0] PH_SP_HIGH   = 5'd16;
  localparam logic [4:0] PH_SP_REL    = 5'd17;
  localparam logic [4:0] PH_SP_WAIT   = 5'd18;

  localparam logic [DelayW-1:0] DelayReset = DelayW'(100);

  logic [DelayW-1:0] dly_cfg_q;
  logic [4:0]        phase_q, phase_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [DelayW-1:0] dly_q, dly_d;
  logic              ack_choice_q, ack_choice_d;
  logic              ack_flag_q, ack_flag_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [7:0]        rx_q, rx_d;
  logic              out_vld_q, out_vld_d;
  res_t              out_res_q;
  res_t              res_d;

  logic              step;
  logic              done, rej;
  logic              dly_over;
  logic [DelayW-1:0] dly_dec;
  logic [3:0]        cnt_nx;

  assign step      = cmd_valid_i && (!out_vld_q || res_ready_i);
  assign cmd_pop_o = step;
  assign dly_over  = (dly_q <= DelayW'(1));
  assign dly_dec   = dly_over ? '0 : dly_q - DelayW'(1);
  assign cnt_nx    = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    dly_d        = dly_q;
    ack_choice_d = ack_choice_q;
    ack_flag_d   = ack_flag_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    rx_d         = rx_q;
    done         = 1'b0;
    rej          = 1'b0;

    if (step) begin
      case (cmd_i.kind)
        KIND_TICK: begin
          case (phase_q)
            PH_IDLE: begin
            end
            PH_ST_WAIT: begin
              if (cmd_i.scl_in && cmd_i.sda_in) begin
                sda_d   = 1'b1;
                dly_d   = dly_cfg_q;
                phase_d = PH_ST_D1;
              end
            end
            PH_ST_D1: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d   = 1'b1;
                dly_d   = dly_cfg_q;
                phase_d = PH_ST_D2;
              end
            end
            PH_ST_D2: begin
              dly_d = dly_dec;
              if (dly_over) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            PH_WR_SETUP: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d   = 1'b0;
                dly_d   = dly_cfg_q;
                phase_d = PH_WR_HIGH;
              end
            end
            PH_WR_HIGH: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d     = 1'b1;
                shift_d   = {shift_q[6:0], 1'b0};
                bit_cnt_d = cnt_nx;
                dly_d     = dly_cfg_q;
                if (cnt_nx > 4'd7) begin
                  sda_d   = 1'b0;
                  phase_d = PH_WR_ASETUP;
                end else begin
                  // next bit is the new MSB after the shift
                  sda_d   = ~shift_q[6];
                  phase_d = PH_WR_SETUP;
                end
              end
            end
            PH_WR_ASETUP: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d   = 1'b0;
                dly_d   = dly_cfg_q;
                phase_d = PH_WR_AHIGH;
              end
            end
            PH_WR_AHIGH: begin
              dly_d = dly_dec;
              if (dly_over) begin
                phase_d = PH_WR_AWAIT;
              end
            end
            PH_WR_AWAIT: begin
              // hold here while the slave stretches the clock
              if (cmd_i.scl_in) begin
                ack_flag_d = ~cmd_i.sda_in;
                scl_d      = 1'b1;
                dly_d      = dly_cfg_q;
                phase_d    = PH_WR_AEND;
              end
            end
            PH_WR_AEND: begin
              dly_d = dly_dec;
              if (dly_over) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            PH_RD_HIGH: begin
              dly_d = dly_dec;
              if (dly_over) begin
                shift_d = {shift_q[6:0], cmd_i.sda_in};
                scl_d   = 1'b1;
                dly_d   = dly_cfg_q;
                phase_d = PH_RD_LOW;
              end
            end
            PH_RD_LOW: begin
              dly_d = dly_dec;
              if (dly_over) begin
                bit_cnt_d = cnt_nx;
                dly_d     = dly_cfg_q;
                if (cnt_nx > 4'd7) begin
                  sda_d   = ack_choice_q;
                  phase_d = PH_RD_ASETUP;
                end else begin
                  scl_d   = 1'b0;
                  phase_d = PH_RD_HIGH;
                end
              end
            end
            PH_RD_ASETUP: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d   = 1'b0;
                dly_d   = dly_cfg_q;
                phase_d = PH_RD_AHIGH;
              end
            end
            PH_RD_AHIGH: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d   = 1'b1;
                dly_d   = dly_cfg_q;
                phase_d = PH_RD_AEND;
              end
            end
            PH_RD_AEND: begin
              dly_d = dly_dec;
              if (dly_over) begin
                sda_d   = 1'b0;
                rx_d    = shift_q;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            PH_SP_LOW: begin
              dly_d = dly_dec;
              if (dly_over) begin
                scl_d   = 1'b0;
                dly_d   = dly_cfg_q;
                phase_d = PH_SP_HIGH;
              end
            end
            PH_SP_HIGH: begin
              dly_d = dly_dec;
              if (dly_over) begin
                sda_d   = 1'b0;
                dly_d   = dly_cfg_q;
                phase_d = PH_SP_REL;
              end
            end
            PH_SP_REL: begin
              dly_d = dly_dec;
              if (dly_over) begin
                phase_d = PH_SP_WAIT;
              end
            end
            PH_SP_WAIT: begin
              if (cmd_i.scl_in && cmd_i.sda_in) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        KIND_START, KIND_WRITE, KIND_READ, KIND_STOP: begin
          if (phase_q != PH_IDLE) begin
            rej = 1'b1;
          end else begin
            case (cmd_i.kind)
              KIND_START: begin
                sda_d   = 1'b0;
                scl_d   = 1'b0;
                phase_d = PH_ST_WAIT;
              end
              KIND_WRITE: begin
                shift_d   = cmd_i.data_byte;
                bit_cnt_d = 4'd0;
                sda_d     = ~cmd_i.data_byte[7];
                dly_d     = dly_cfg_q;
                phase_d   = PH_WR_SETUP;
              end
              KIND_READ: begin
                shift_d      = 8'd0;
                bit_cnt_d    = 4'd0;
                ack_choice_d = cmd_i.send_ack;
                sda_d        = 1'b0;
                scl_d        = 1'b0;
                dly_d        = dly_cfg_q;
                phase_d      = PH_RD_HIGH;
              end
              default: begin
                scl_d   = 1'b1;
                sda_d   = 1'b1;
                dly_d   = dly_cfg_q;
                phase_d = PH_SP_LOW;
              end
            endcase
          end
        end
        default: begin
          // unused op codes leave every state bit alone
        end
      endcase
    end
  end

  always_comb begin
    res_d.rejected = rej;
    res_d.busy_res = (phase_d != PH_IDLE);
    res_d.ack_seen = ack_flag_d;
    res_d.rx_byte  = rx_d;
    res_d.done_res = done;
    res_d.sda_low  = sda_d;
    res_d.scl_low  = scl_d;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (res_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_cfg_q    <= DelayReset;
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= 4'd0;
      shift_q      <= 8'd0;
      dly_q        <= '0;
      ack_choice_q <= 1'b0;
      ack_flag_q   <= 1'b0;
      scl_q        <= 1'b0;
      sda_q        <= 1'b0;
      rx_q         <= 8'd0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dly_cfg_q <= cfg_wdata_i;
      end
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      dly_q        <= dly_d;
      ack_choice_q <= ack_choice_d;
      ack_flag_q   <= ack_flag_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      rx_q         <= rx_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res_d;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_res_q;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_byte_engine.sv =====
// I2C master byte engine: start, write, read and stop sequencing from tick items.
//
// Input stream: each transfer is one item, either a tick carrying the sampled
// SCL/SDA levels or a bus command (start, write byte, read byte, stop). Every
// item yields exactly one result transfer with the pin drives, a done pulse,
// the last received byte, the last acknowledge seen, busy and rejected flags.
// Commands that arrive while a command is still running are rejected.
// A result is presented the cycle after its item leaves the two-entry input
// queue; each item passes through the queue and then the result register.
// Throughput: one item per clock while the receiver takes results; each item is one step of the bus sequencer.
// Bus timing is set by delay_ticks (cfg_we_i/cfg_wdata_i): each delay step
// lasts that many tick items, a value of zero acting as one.
// When the receiver stalls, the result register holds, the queue absorbs two
// more items and then s_axis_tready drops until results drain.
// Reset: both lines released, sequencer idle, delay_ticks = 100, received
// byte and acknowledge cleared, queue and result register empty.
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DelayW-1:0] cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] data_byte, [8] send_ack, [9] scl_in, [10] sda_in, [15:11] zero
  input  wire logic [15:0]       s_axis_tdata,
  // [2:0] op
  input  wire logic [2:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] scl_low, [1] sda_low, [2] done_res, [10:3] rx_byte, [11] ack_seen,
  // [12] busy_res, [13] rejected, [15:14] zero
  output logic [15:0]            m_axis_tdata
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  i2cm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .data_byte_i (s_axis_tdata[7:0]),
    .send_ack_i  (s_axis_tdata[8]),
    .scl_in_i    (s_axis_tdata[9]),
    .sda_in_i    (s_axis_tdata[10]),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.rejected, res.busy_res, res.ack_seen, res.rx_byte,
                         res.done_res, res.sda_low, res.scl_low};

  // A completing command leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.done_res |-> !res.busy_res)
    else $error("done result reports busy");

  // A rejected command never completes anything and only happens while busy
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.rejected |-> res.busy_res && !res.done_res)
    else $error("rejected result inconsistent with busy/done");

  // The queue only drains into the back end when an item is waiting
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end stepped without a queued item");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for the I2C master byte engine: directed table, random bus traffic, then a longest-delay start.
module tb_top
  import i2cm_pkg::*;
();

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int NumPhases = 7;
  localparam int PhaseDelays [NumPhases] = '{1, 0, 2, 3, 1, 6, 2};
  localparam logic [15:0] DelayMax = 16'hFFFF;

  typedef enum logic [4:0] {
    BP_IDLE, BP_START_WAIT, BP_START_D1, BP_START_D2,
    BP_WR_SETUP, BP_WR_HIGH, BP_WR_ACK_SETUP, BP_WR_ACK_HIGH, BP_WR_ACK_WAIT, BP_WR_ACK_END,
    BP_RD_HIGH, BP_RD_LOW, BP_RD_ACK_SETUP, BP_RD_ACK_HIGH, BP_RD_ACK_END,
    BP_SP_LOW, BP_SP_HIGH, BP_SP_REL, BP_SP_WAIT
  } bus_phase_e;

  typedef struct {
    logic [2:0] op;
    logic [7:0] data;
    logic       ack;
    logic       scl;
    logic       sda;
    logic       typed;
    res_t       want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [DelayW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic [2:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;

  i2c_master_byte_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Engine state as the bench expects it
  bus_phase_e  ph = BP_IDLE;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] dly_cnt = '0;
  logic        ack_pick = 1'b0;
  logic        ack_got = 1'b0;
  logic        scl_pull = 1'b0;
  logic        sda_pull = 1'b0;
  logic [7:0]  rx_hold = '0;
  logic [15:0] cfg_delay = 16'd100;

  res_t bus_res_q [$];
  int   fail_cnt = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  bit   bus_owned = 1'b0;

  function automatic void load_step(input bus_phase_e nxt);
    dly_cnt = cfg_delay;
    ph = nxt;
  endfunction

  // Count one tick of the current step; true when the step ends
  function automatic logic step_elapsed();
    if (dly_cnt > 16'd1) begin
      dly_cnt = dly_cnt - 16'd1;
      return 1'b0;
    end
    dly_cnt = '0;
    return 1'b1;
  endfunction

  function automatic logic bus_advance(input logic sc, input logic sd);
    case (ph)
      BP_START_WAIT: begin
        if (sc && sd) begin
          sda_pull = 1'b1;
          load_step(BP_START_D1);
        end
      end
      BP_START_D1: begin
        if (step_elapsed()) begin
          scl_pull = 1'b1;
          load_step(BP_START_D2);
        end
      end
      BP_START_D2: begin
        if (step_elapsed()) begin
          ph = BP_IDLE;
          return 1'b1;
        end
      end
      BP_WR_SETUP: begin
        if (step_elapsed()) begin
          scl_pull = 1'b0;
          load_step(BP_WR_HIGH);
        end
      end
      BP_WR_HIGH: begin
        if (step_elapsed()) begin
          scl_pull = 1'b1;
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt > 4'd7) begin
            sda_pull = 1'b0;
            load_step(BP_WR_ACK_SETUP);
          end else begin
            sda_pull = ~shreg[7];
            load_step(BP_WR_SETUP);
          end
        end
      end
      BP_WR_ACK_SETUP: begin
        if (step_elapsed()) begin
          scl_pull = 1'b0;
          load_step(BP_WR_ACK_HIGH);
        end
      end
      BP_WR_ACK_HIGH: begin
        if (step_elapsed()) ph = BP_WR_ACK_WAIT;
      end
      BP_WR_ACK_WAIT: begin
        // hold until the slave lets SCL rise
        if (sc) begin
          ack_got = ~sd;
          scl_pull = 1'b1;
          load_step(BP_WR_ACK_END);
        end
      end
      BP_WR_ACK_END: begin
        if (step_elapsed()) begin
          ph = BP_IDLE;
          return 1'b1;
        end
      end
      BP_RD_HIGH: begin
        if (step_elapsed()) begin
          shreg = {shreg[6:0], sd};
          scl_pull = 1'b1;
          load_step(BP_RD_LOW);
        end
      end
      BP_RD_LOW: begin
        if (step_elapsed()) begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt > 4'd7) begin
            sda_pull = ack_pick;
            load_step(BP_RD_ACK_SETUP);
          end else begin
            scl_pull = 1'b0;
            load_step(BP_RD_HIGH);
          end
        end
      end
      BP_RD_ACK_SETUP: begin
        if (step_elapsed()) begin
          scl_pull = 1'b0;
          load_step(BP_RD_ACK_HIGH);
        end
      end
      BP_RD_ACK_HIGH: begin
        if (step_elapsed()) begin
          scl_pull = 1'b1;
          load_step(BP_RD_ACK_END);
        end
      end
      BP_RD_ACK_END: begin
        if (step_elapsed()) begin
          sda_pull = 1'b0;
          rx_hold = shreg;
          ph = BP_IDLE;
          return 1'b1;
        end
      end
      BP_SP_LOW: begin
        if (step_elapsed()) begin
          scl_pull = 1'b0;
          load_step(BP_SP_HIGH);
        end
      end
      BP_SP_HIGH: begin
        if (step_elapsed()) begin
          sda_pull = 1'b0;
          load_step(BP_SP_REL);
        end
      end
      BP_SP_REL: begin
        if (step_elapsed()) ph = BP_SP_WAIT;
      end
      BP_SP_WAIT: begin
        if (sc && sd) begin
          ph = BP_IDLE;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic res_t engine_step(input logic [2:0] op, input logic [7:0] d,
                                       input logic a, input logic sc, input logic sd);
    res_t r;
    logic fin;
    logic rej;
    fin = 1'b0;
    rej = 1'b0;
    if (op == OP_TICK) begin
      fin = bus_advance(sc, sd);
    end else if (op <= OP_STOP) begin
      if (ph != BP_IDLE) begin
        rej = 1'b1;
      end else begin
        case (op)
          OP_START: begin
            sda_pull = 1'b0;
            scl_pull = 1'b0;
            ph = BP_START_WAIT;
          end
          OP_WRITE: begin
            shreg = d;
            bit_cnt = '0;
            sda_pull = ~d[7];
            load_step(BP_WR_SETUP);
          end
          OP_READ: begin
            shreg = '0;
            bit_cnt = '0;
            ack_pick = a;
            sda_pull = 1'b0;
            scl_pull = 1'b0;
            load_step(BP_RD_HIGH);
          end
          default: begin
            scl_pull = 1'b1;
            sda_pull = 1'b1;
            load_step(BP_SP_LOW);
          end
        endcase
      end
    end
    r.scl_low  = scl_pull;
    r.sda_low  = sda_pull;
    r.done_res = fin;
    r.rx_byte  = rx_hold;
    r.ack_seen = ack_got;
    r.busy_res = (ph != BP_IDLE);
    r.rejected = rej;
    return r;
  endfunction

  // Result bits: [0] scl_low [1] sda_low [2] done [10:3] rx_byte [11] ack [12] busy [13] rejected
  stim_row_t dir_rows [22] = '{
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h0000)},  // tick while idle
    '{OP_SPARE_LO, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, res_t'(14'h0000)},  // unused op
    '{OP_SPARE_HI, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h0000)},
    '{OP_START,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h1000)},
    '{OP_WRITE,    8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, res_t'(14'h3000)},  // busy: reject
    '{OP_READ,     8'h00, 1'b1, 1'b1, 1'b1, 1'b1, res_t'(14'h3000)},
    '{OP_STOP,     8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h3000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b1, 1'b0, res_t'(14'h0000)},  // bus not free yet
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h0007)},  // start done
    '{OP_STOP,     8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h1003)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b0, 1'b1, 1'b0, res_t'(14'h0000)},  // stop waits on lines
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b1, res_t'(14'h0004)},  // stop done
    '{OP_WRITE,    8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_READ,     8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)},
    '{OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000)}
  };

  task automatic write_delay(input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_delay = v;
  endtask

  task automatic send_item(input logic [2:0] op, input logic [7:0] d, input logic a,
                           input logic sc, input logic sd, input logic typed, input res_t want);
    res_t r;
    if (burst_left == 0) begin
      if (gaps_on && $urandom_range(0, 9) < 7) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'b0, sd, sc, a, d};
    do @(posedge clk_i); while (!s_axis_tready);
    r = engine_step(op, d, a, sc, sd);
    bus_res_q.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (bus_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed bus traffic driven off the expected engine state
  task automatic pick_item(output logic [2:0] op, output logic [7:0] d, output logic a,
                           output logic sc, output logic sd);
    int roll;
    int sel;
    roll = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    d = (sel < 10) ? 8'h00 : (sel < 20) ? 8'hFF : 8'($urandom_range(0, 255));
    a = 1'($urandom_range(0, 1));
    sc = 1'b1;
    sd = 1'b1;
    op = OP_TICK;
    sel = $urandom_range(0, 99);
    if (roll < 4) begin
      // noise: anything the fields allow
      op = 3'($urandom_range(0, 7));
      sc = 1'($urandom_range(0, 1));
      sd = 1'($urandom_range(0, 1));
      if (ph == BP_IDLE && op == OP_START) bus_owned = 1'b1;
      if (ph == BP_IDLE && op == OP_STOP) bus_owned = 1'b0;
    end else if (ph == BP_IDLE) begin
      if (!bus_owned) begin
        op = (sel < 90) ? OP_START : (sel < 94) ? OP_WRITE : (sel < 97) ? OP_READ : OP_STOP;
      end else begin
        op = (sel < 45) ? OP_WRITE : (sel < 75) ? OP_READ : (sel < 90) ? OP_STOP : OP_START;
      end
      if (op == OP_START) bus_owned = 1'b1;
      if (op == OP_STOP) bus_owned = 1'b0;
    end else begin
      sc = scl_pull ? 1'b0 : ($urandom_range(0, 9) != 0);
      if (sda_pull) sd = 1'b0;
      else if (ph == BP_RD_HIGH || ph == BP_RD_LOW) sd = 1'($urandom_range(0, 1));
      else if (ph == BP_WR_ACK_HIGH || ph == BP_WR_ACK_WAIT) sd = ($urandom_range(0, 3) == 0);
      else sd = ($urandom_range(0, 9) != 0);
    end
  endtask

  task automatic run_random(input int n);
    int counted;
    logic [2:0] op;
    logic [7:0] d;
    logic a, sc, sd;
    counted = 0;
    while (counted < n || ph != BP_IDLE) begin
      pick_item(op, d, a, sc, sd);
      if (op <= OP_STOP && !(op == OP_TICK && ph == BP_IDLE)) counted++;
      send_item(op, d, a, sc, sd, 1'b0, res_t'(14'h0000));
    end
  endtask

  // Receiver stall pattern, reloaded when its countdown runs out
  logic [31:0] ready_pat = '1;
  int          pat_left = 0;

  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat <= '1;
        1: ready_pat <= $urandom | $urandom;
        2: ready_pat <= $urandom;
        default: ready_pat <= $urandom & $urandom;
      endcase
      pat_left <= 31;
    end else begin
      ready_pat <= ready_pat >> 1;
      pat_left <= pat_left - 1;
    end
    m_axis_tready <= ready_pat[0];
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[13:0]);
      if (bus_res_q.size() == 0) begin
        $error("result transfer with nothing pending: tdata %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = bus_res_q.pop_front();
        check_field("scl_low", 8'(want.scl_low), 8'(got.scl_low));
        check_field("sda_low", 8'(want.sda_low), 8'(got.sda_low));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("rejected", 8'(want.rejected), 8'(got.rejected));
        check_field("tdata pad", 8'h00, 8'(m_axis_tdata[15:14]));
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_delay(16'd0);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].ack, dir_rows[i].scl,
                dir_rows[i].sda, dir_rows[i].typed, dir_rows[i].want);
    end
    run_random(150);
    wait_drained();

    for (int k = 0; k < NumPhases; k++) begin
      write_delay(16'(PhaseDelays[k]));
      gaps_on = ($urandom_range(0, 3) != 0);
      run_random(250);
      wait_drained();
    end

    // Longest step: open a start and let the count run a while, then poke it
    write_delay(DelayMax);
    gaps_on = 1'b0;
    send_item(OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000));
    repeat (40) send_item(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000));
    send_item(OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, res_t'(14'h0000));
    send_item(OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, res_t'(14'h0000));
    wait_drained();

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
